// ----- design/rde_pkg.sv -----
// Package for the restoring divider with Euclidean signed results.
// Holds the mode codes and the operand sign flags that travel down the pipeline.
// No dependencies.
`default_nettype none

package rde_pkg;

  localparam logic MODE_SIGNED   = 1'b0;
  localparam logic MODE_UNSIGNED = 1'b1;

  typedef struct packed {
    logic x_neg;
    logic y_neg;
  } rde_sign_t;

endpackage

`default_nettype wire

// ----- design/rde_if.sv -----
// Handshake interfaces for the divider: the operand channel and the result channel.
// Each one carries valid, ready and two data words; the operand channel adds mode.
// No dependencies.
`default_nettype none

interface rde_in_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] dividend;
  logic [DATA_WIDTH-1:0] divisor;
  logic                  mode;

  modport source (output valid, dividend, divisor, mode, input ready);
  modport sink   (input valid, dividend, divisor, mode, output ready);
endinterface

interface rde_out_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] quotient;
  logic [DATA_WIDTH-1:0] remainder;

  modport source (output valid, quotient, remainder, input ready);
  modport sink   (input valid, quotient, remainder, output ready);
endinterface

`default_nettype wire

// ----- design/rde_prep.sv -----
// Operand stage of the divider: decodes the mode and takes operand magnitudes.
// Depends on rde_pkg.
`default_nettype none

module rde_prep #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [DATA_WIDTH-1:0] dividend_i,
  input  wire logic [DATA_WIDTH-1:0] divisor_i,
  input  wire logic                  mode_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic [DATA_WIDTH-1:0]      lower_o,
  output logic [DATA_WIDTH-1:0]      ymag_o,
  output rde_pkg::rde_sign_t         sign_o
);
  import rde_pkg::*;

  logic                  valid_q;
  logic [DATA_WIDTH-1:0] lower_q, lower_d;
  logic [DATA_WIDTH-1:0] ymag_q, ymag_d;
  rde_sign_t             sign_q, sign_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    sign_d.x_neg = (mode_i == MODE_SIGNED) && dividend_i[DATA_WIDTH-1];
    sign_d.y_neg = (mode_i == MODE_SIGNED) && divisor_i[DATA_WIDTH-1];
    lower_d      = sign_d.x_neg ? (~dividend_i + 1'b1) : dividend_i;
    ymag_d       = sign_d.y_neg ? (~divisor_i + 1'b1) : divisor_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      lower_q <= lower_d;
      ymag_q  <= ymag_d;
      sign_q  <= sign_d;
    end
  end

  assign valid_o = valid_q;
  assign lower_o = lower_q;
  assign ymag_o  = ymag_q;
  assign sign_o  = sign_q;

endmodule

`default_nettype wire

// ----- design/rde_step.sv -----
// One restoring shift-and-subtract step of the divider, as one pipeline stage.
// Depends on rde_pkg.
`default_nettype none

module rde_step #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [DATA_WIDTH-1:0] upper_i,
  input  wire logic [DATA_WIDTH-1:0] lower_i,
  input  wire logic [DATA_WIDTH-1:0] ymag_i,
  input  rde_pkg::rde_sign_t         sign_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic [DATA_WIDTH-1:0]      upper_o,
  output logic [DATA_WIDTH-1:0]      lower_o,
  output logic [DATA_WIDTH-1:0]      ymag_o,
  output rde_pkg::rde_sign_t         sign_o
);
  import rde_pkg::*;

  logic                  valid_q;
  logic [DATA_WIDTH-1:0] upper_q, upper_d;
  logic [DATA_WIDTH-1:0] lower_q, lower_d;
  logic [DATA_WIDTH-1:0] ymag_q;
  rde_sign_t             sign_q;
  logic [DATA_WIDTH-1:0] trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;

  assign ready_o = !valid_q || ready_i;

  // The shifted partial remainder keeps only DATA_WIDTH bits.
  always_comb begin
    trial   = {upper_i[DATA_WIDTH-2:0], lower_i[DATA_WIDTH-1]};
    diff    = {1'b0, trial} - {1'b0, ymag_i};
    fits    = !diff[DATA_WIDTH];
    upper_d = fits ? diff[DATA_WIDTH-1:0] : trial;
    lower_d = {lower_i[DATA_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      upper_q <= upper_d;
      lower_q <= lower_d;
      ymag_q  <= ymag_i;
      sign_q  <= sign_i;
    end
  end

  assign valid_o = valid_q;
  assign upper_o = upper_q;
  assign lower_o = lower_q;
  assign ymag_o  = ymag_q;
  assign sign_o  = sign_q;

endmodule

`default_nettype wire

// ----- design/rde_fixup.sv -----
// Result stages of the divider: Euclidean correction, then quotient sign.
// Two register stages; the second one is the output register. Depends on rde_pkg.
`default_nettype none

module rde_fixup #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [DATA_WIDTH-1:0] upper_i,
  input  wire logic [DATA_WIDTH-1:0] lower_i,
  input  wire logic [DATA_WIDTH-1:0] ymag_i,
  input  rde_pkg::rde_sign_t         sign_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic [DATA_WIDTH-1:0]      quotient_o,
  output logic [DATA_WIDTH-1:0]      remainder_o
);
  import rde_pkg::*;

  logic                  va_q, vb_q;
  logic                  ready_a, ready_b;
  logic                  corr;
  logic [DATA_WIDTH-1:0] quot_q, quot_d;
  logic [DATA_WIDTH-1:0] rem_a_q, rem_a_d;
  logic                  neg_q, neg_d;
  logic [DATA_WIDTH-1:0] quo_b_q, quo_b_d;
  logic [DATA_WIDTH-1:0] rem_b_q;

  assign ready_b = !vb_q || ready_i;
  assign ready_a = !va_q || ready_b;
  assign ready_o = ready_a;

  // A negative dividend with a nonzero remainder moves the quotient one step
  // further from zero so that the remainder becomes nonnegative.
  always_comb begin
    corr    = sign_i.x_neg && (upper_i != '0);
    quot_d  = lower_i + {{(DATA_WIDTH-1){1'b0}}, corr};
    rem_a_d = corr ? (ymag_i - upper_i) : upper_i;
    neg_d   = sign_i.x_neg ^ sign_i.y_neg;
    quo_b_d = neg_q ? (~quot_q + 1'b1) : quot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) begin
        va_q <= valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      quot_q  <= quot_d;
      rem_a_q <= rem_a_d;
      neg_q   <= neg_d;
    end
    if (ready_b && va_q) begin
      quo_b_q <= quo_b_d;
      rem_b_q <= rem_a_q;
    end
  end

  assign valid_o     = vb_q;
  assign quotient_o  = quo_b_q;
  assign remainder_o = rem_b_q;

endmodule

`default_nettype wire

// ----- design/restoring_divider_euclidean.sv -----
// Top level of the pipelined restoring divider with Euclidean signed results.
// Depends on rde_pkg, rde_if, rde_prep, rde_step and rde_fixup.
//
// Usage: operands arrive on in_i (dividend, divisor, mode; mode 0 is signed
// Euclidean division, mode 1 is unsigned division) and results leave on out_o
// (quotient, remainder). A word moves when valid and ready are both high.
// In signed mode the remainder always lies in 0 to |divisor|-1. A zero divisor
// or the most negative dividend over minus one raises no flag.
// The pipeline has one operand stage, one stage for each of the DATA_WIDTH
// shift-and-subtract steps, one correction stage and one output stage.
// Throughput is one word per cycle while out_o.ready stays high.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor takes its word, so bubbles close up. When the receiver stalls,
// the words pile up stage by stage and in_i.ready falls only once every
// stage is full; nothing is lost or repeated.
// Reset clears all valid bits and leaves the block empty and ready.
`default_nettype none

module restoring_divider_euclidean #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rde_in_if.sink    in_i,
  rde_out_if.source out_o
);
  import rde_pkg::*;

  logic [DATA_WIDTH:0]                 valid_w;
  logic [DATA_WIDTH:0]                 ready_w;
  logic [DATA_WIDTH:0][DATA_WIDTH-1:0] upper_w;
  logic [DATA_WIDTH:0][DATA_WIDTH-1:0] lower_w;
  logic [DATA_WIDTH:0][DATA_WIDTH-1:0] ymag_w;
  rde_sign_t [DATA_WIDTH:0]            sign_w;

  rde_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_i.valid),
    .ready_o    (in_i.ready),
    .dividend_i (in_i.dividend),
    .divisor_i  (in_i.divisor),
    .mode_i     (in_i.mode),
    .valid_o    (valid_w[0]),
    .ready_i    (ready_w[0]),
    .lower_o    (lower_w[0]),
    .ymag_o     (ymag_w[0]),
    .sign_o     (sign_w[0])
  );

  assign upper_w[0] = '0;

  for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
    rde_step #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[g]),
      .ready_o (ready_w[g]),
      .upper_i (upper_w[g]),
      .lower_i (lower_w[g]),
      .ymag_i  (ymag_w[g]),
      .sign_i  (sign_w[g]),
      .valid_o (valid_w[g+1]),
      .ready_i (ready_w[g+1]),
      .upper_o (upper_w[g+1]),
      .lower_o (lower_w[g+1]),
      .ymag_o  (ymag_w[g+1]),
      .sign_o  (sign_w[g+1])
    );
  end

  rde_fixup #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_fixup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_w[DATA_WIDTH]),
    .ready_o     (ready_w[DATA_WIDTH]),
    .upper_i     (upper_w[DATA_WIDTH]),
    .lower_i     (lower_w[DATA_WIDTH]),
    .ymag_i      (ymag_w[DATA_WIDTH]),
    .sign_i      (sign_w[DATA_WIDTH]),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .quotient_o  (out_o.quotient),
    .remainder_o (out_o.remainder)
  );

endmodule

`default_nettype wire
